### hw/rtl/sbpc_pkg.sv
package sbpc_pkg;

   localparam int NUM_BLOCK_COLS_DEF  = 1024;
   localparam int MAX_BLOCK_ELEMS_DEF = 32;

   localparam logic [1:0] OP_NONZERO = 2'd0;
   localparam logic [1:0] OP_END_ROW = 2'd1;
   localparam logic [1:0] OP_DRAIN   = 2'd2;

   localparam logic [2:0] ST_ACCEPT = 3'd0;
   localparam logic [2:0] ST_VALUE  = 3'd1;
   localparam logic [2:0] ST_IDLE   = 3'd2;
   localparam logic [2:0] ST_BUSY   = 3'd3;
   localparam logic [2:0] ST_BAD    = 3'd4;

   localparam logic [1:0] REG_HEIGHT = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] row_index;
      logic [14:0] col_index;
      logic [63:0] element_value;
      logic        stripe_end;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] block_row;
      logic [9:0]  block_col;
      logic [31:0] pattern;
      logic [63:0] out_value;
      logic        last_of_block;
      logic        last_of_block_row;
      logic [31:0] block_total;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic start;     // latch request, begin divide
      logic div_step;  // one quotient bit step
      logic lookup;    // read per-column stores
      logic execute;   // commit result and write back
      logic clear_row; // clearing pass step
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_done;
      logic clear_done;
   } sts_type;

endpackage

### hw/rtl/sbpc_datapath.sv
module sbpc_datapath
   import sbpc_pkg::*;
#(
   parameter int NUM_BLOCK_COLS  = NUM_BLOCK_COLS_DEF,
   parameter int MAX_BLOCK_ELEMS = MAX_BLOCK_ELEMS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  req_type     req_data,
   input  logic [5:0]  height,
   input  logic [5:0]  width,
   output rsp_type     rsp_data
);
   localparam int BCW = (NUM_BLOCK_COLS > 1) ? $clog2(NUM_BLOCK_COLS) : 1;
   localparam int TCW = $clog2(NUM_BLOCK_COLS + 1);
   localparam int EW  = (MAX_BLOCK_ELEMS > 1) ? $clog2(MAX_BLOCK_ELEMS) : 1;
   localparam int FCW = $clog2(MAX_BLOCK_ELEMS + 1);
   localparam int VAW = BCW + EW;

   // stores; value store is addressed {block column, element slot}
   logic [31:0]  pat_mem  [NUM_BLOCK_COLS];
   logic [FCW-1:0] fill_mem [NUM_BLOCK_COLS];
   logic [63:0]  val_mem  [NUM_BLOCK_COLS << EW];
   logic [BCW-1:0] touch_mem [NUM_BLOCK_COLS];

   req_type      req_ff;
   logic [31:0]  rq_ff, rr_ff;   // row / height
   logic [14:0]  cq_ff, cr_ff;   // col / width
   logic [5:0]   cnt_ff;
   logic         done_ff;

   logic [TCW-1:0] touched_count_ff, drain_pos_ff;
   logic [FCW-1:0] dvpos_ff;
   logic         draining_ff;
   logic [31:0]  closed_row_ff, emitted_ff;
   logic [BCW:0] clr_ff;

   logic [31:0]  pat_rd_ff;
   logic [FCW-1:0] fill_rd_ff;
   logic [63:0]  val_rd_ff;
   logic [BCW-1:0] bc_ff;
   logic         bc_ok_ff;
   rsp_type      rsp_ff;

   // restoring dividers: row by height and col by width, one bit per step
   logic [32:0] rtrial;
   logic [15:0] ctrial;
   assign rtrial = {rr_ff, rq_ff[31]} - {27'd0, height};
   assign ctrial = {cr_ff, cq_ff[14]} - {10'd0, width};

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         req_ff <= req_data;
         rq_ff  <= req_data.row_index;
         rr_ff  <= '0;
         cq_ff  <= req_data.col_index;
         cr_ff  <= '0;
      end else if (cmd.div_step) begin
         if (cnt_ff < 6'd32) begin
            if (!rtrial[32]) begin
               rr_ff <= rtrial[31:0];
               rq_ff <= {rq_ff[30:0], 1'b1};
            end else begin
               rr_ff <= {rr_ff[30:0], rq_ff[31]};
               rq_ff <= {rq_ff[30:0], 1'b0};
            end
         end
         if (cnt_ff < 6'd15) begin
            if (!ctrial[15]) begin
               cr_ff <= ctrial[14:0];
               cq_ff <= {cq_ff[13:0], 1'b1};
            end else begin
               cr_ff <= {cr_ff[13:0], cq_ff[14]};
               cq_ff <= {cq_ff[13:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.start) begin
         cnt_ff <= '0;
      end else if (cmd.div_step && cnt_ff != 6'd32) begin
         cnt_ff <= cnt_ff + 6'd1;
      end
   end
   assign sts.div_done = (cnt_ff == 6'd32);

   // touched list is read every cycle; drain_pos_ff only moves on execute
   logic [BCW-1:0] touch_rd_ff;
   always_ff @(posedge clock) begin
      touch_rd_ff <= touch_mem[drain_pos_ff[BCW-1:0]];
   end

   // block column for lookup
   logic [BCW-1:0] bc_in;
   logic bc_ok_in, drain_act;
   assign drain_act = draining_ff && (drain_pos_ff < touched_count_ff);
   always_comb begin
      if (req_ff.operation == OP_DRAIN) begin
         bc_in    = touch_rd_ff;
         bc_ok_in = 1'b1;
      end else begin
         bc_in    = BCW'(cq_ff);
         bc_ok_in = ({17'd0, cq_ff} < 32'(NUM_BLOCK_COLS));
      end
   end

   logic [FCW-1:0] dv_cl;
   assign dv_cl = (dvpos_ff >= FCW'(MAX_BLOCK_ELEMS)) ? FCW'(MAX_BLOCK_ELEMS - 1) : dvpos_ff;

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         bc_ff      <= bc_in;
         bc_ok_ff   <= bc_ok_in;
         pat_rd_ff  <= pat_mem[bc_in];
         fill_rd_ff <= fill_mem[bc_in];
         val_rd_ff  <= val_mem[{bc_in, dv_cl[EW-1:0]}];
      end
   end

   // execute
   logic size_ok;
   logic [11:0] hw_prod;
   assign hw_prod = height * width;
   assign size_ok = (height != 0) && (width != 0) && (hw_prod <= 12'd32);

   logic [10:0] pos;
   assign pos = 11'(rr_ff[4:0] * width) + 11'(cr_ff);

   logic lb, lr;
   assign lb = ({1'b0, dv_cl} + 1'b1) >= {1'b0, fill_rd_ff};
   assign lr = lb && ((drain_pos_ff + 1'b1) >= touched_count_ff);

   logic drain_val;
   assign drain_val = cmd.execute && req_ff.operation == OP_DRAIN && drain_act;

   logic [31:0] em_next;
   assign em_next = (drain_val && lb && emitted_ff != '1) ? emitted_ff + 32'd1 : emitted_ff;

   logic pat_we, fill_we, val_we, touch_we;
   logic [BCW-1:0] pat_wa;
   logic [31:0] pat_wd;
   logic [FCW-1:0] fill_wd;
   logic [VAW-1:0] val_wa;
   logic [TCW-1:0] tc_nx;
   rsp_type rsp_in;

   always_comb begin
      pat_we = 1'b0; fill_we = 1'b0; val_we = 1'b0; touch_we = 1'b0;
      pat_wa = bc_ff; pat_wd = '0; fill_wd = '0;
      val_wa = {bc_ff, fill_rd_ff[EW-1:0]};
      tc_nx = touched_count_ff;
      rsp_in = '0;
      rsp_in.status = ST_BAD;
      if (cmd.clear_row) begin
         pat_we = 1'b1; fill_we = 1'b1;
         pat_wa = clr_ff[BCW-1:0];
      end else if (cmd.execute) begin
         unique case (req_ff.operation)
            OP_NONZERO: begin
               if (draining_ff) rsp_in.status = ST_BUSY;
               else if (!size_ok || !bc_ok_ff) rsp_in.status = ST_BAD;
               else if (fill_rd_ff >= FCW'(MAX_BLOCK_ELEMS)) rsp_in.status = ST_BAD;
               else begin
                  rsp_in.status = ST_ACCEPT;
                  pat_we = 1'b1; fill_we = 1'b1; val_we = 1'b1;
                  pat_wd = pat_rd_ff | (32'd1 << pos[4:0]);
                  fill_wd = fill_rd_ff + 1'b1;
                  if (fill_rd_ff == '0 && touched_count_ff < TCW'(NUM_BLOCK_COLS)) begin
                     touch_we = 1'b1;
                     tc_nx = touched_count_ff + 1'b1;
                  end
               end
            end
            OP_END_ROW: begin
               if (draining_ff) rsp_in.status = ST_BUSY;
               else if (!size_ok) rsp_in.status = ST_BAD;
               else rsp_in.status = ST_ACCEPT;
            end
            OP_DRAIN: begin
               if (!drain_act) rsp_in.status = ST_IDLE;
               else begin
                  rsp_in.status = ST_VALUE;
                  rsp_in.block_row = closed_row_ff;
                  rsp_in.block_col = 10'(bc_ff);
                  rsp_in.pattern = pat_rd_ff;
                  rsp_in.out_value = val_rd_ff;
                  rsp_in.last_of_block = lb;
                  rsp_in.last_of_block_row = lr;
                  if (lb) begin
                     pat_we = 1'b1; fill_we = 1'b1;
                  end
                  // last block of the row empties the touched list
                  if (lr) tc_nx = '0;
               end
            end
            default: rsp_in.status = ST_BAD;
         endcase
      end
      rsp_in.block_total = em_next;
   end

   logic closing;
   assign closing = cmd.execute && req_ff.operation == OP_END_ROW && !draining_ff && size_ok
                    && (req_ff.stripe_end || rr_ff == {26'd0, height} - 32'd1);

   always_ff @(posedge clock) begin
      if (pat_we) pat_mem[pat_wa] <= pat_wd;
      if (fill_we) fill_mem[pat_wa] <= fill_wd;
      if (val_we) val_mem[val_wa] <= req_ff.element_value;
      if (touch_we) touch_mem[touched_count_ff[BCW-1:0]] <= bc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touched_count_ff <= '0;
         drain_pos_ff <= '0;
         dvpos_ff <= '0;
         draining_ff <= 1'b0;
         closed_row_ff <= '0;
         emitted_ff <= '0;
         clr_ff <= '0;
      end else begin
         if (cmd.clear_row) clr_ff <= clr_ff + 1'b1;
         touched_count_ff <= tc_nx;
         if (closing) begin
            closed_row_ff <= rq_ff;
            if (touched_count_ff != '0) begin
               draining_ff <= 1'b1;
               drain_pos_ff <= '0;
               dvpos_ff <= '0;
            end
         end
         if (drain_val) begin
            if (lb) begin
               emitted_ff <= em_next;
               dvpos_ff <= '0;
               if (drain_pos_ff + 1'b1 >= touched_count_ff) begin
                  draining_ff <= 1'b0;
                  drain_pos_ff <= '0;
               end else begin
                  drain_pos_ff <= drain_pos_ff + 1'b1;
               end
            end else begin
               dvpos_ff <= dv_cl + 1'b1;
            end
         end
      end
   end
   assign sts.clear_done = clr_ff[BCW] || (clr_ff[BCW-1:0] == BCW'(NUM_BLOCK_COLS - 1));

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end
   assign rsp_data = rsp_ff;

endmodule

### hw/rtl/sbpc_control.sv
module sbpc_control
   import sbpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd,
   input  sts_type sts
);
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DIVIDE = 3'd2;
   localparam logic [2:0] S_LOOKUP = 3'd3;
   localparam logic [2:0] S_EXEC   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic rsp_valid_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_row = 1'b1;
            if (sts.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = S_LOOKUP;
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.execute = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.execute) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

endmodule

### hw/rtl/sparse_block_pattern_collector_top.sv
// Sparse block pattern collector. Each request (nonzero, end of row or drain)
// first passes through a one-bit-per-cycle divider that forms row/height and
// col/width, then a lookup state reads the block-column stores and an execute
// state commits the result into the output register, waiting while the output
// is stalled. After reset a clearing pass over every block column zeroes the
// pattern and fill stores; requests wait until it ends.
module sparse_block_pattern_collector_top
   import sbpc_pkg::*;
#(
   parameter int NUM_BLOCK_COLS  = NUM_BLOCK_COLS_DEF,
   parameter int MAX_BLOCK_ELEMS = MAX_BLOCK_ELEMS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [5:0] height_ff, width_ff;
   cmd_type cmd;
   sts_type sts;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= 6'd1;
         width_ff  <= 6'd1;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2:2] == REG_HEIGHT[0:0] && csr_paddr[1:0] == 2'd0)
            height_ff <= csr_pwdata[5:0];
         else if (csr_paddr[2:2] == REG_WIDTH[0:0] && csr_paddr[1:0] == 2'd0)
            width_ff <= csr_pwdata[5:0];
      end
   end
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == 3'd0) csr_prdata = {26'd0, height_ff};
      else if (csr_paddr == 3'd4) csr_prdata = {26'd0, width_ff};
   end

   sbpc_control u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .sts
   );

   sbpc_datapath #(
      .NUM_BLOCK_COLS(NUM_BLOCK_COLS), .MAX_BLOCK_ELEMS(MAX_BLOCK_ELEMS)
   ) u_dp (
      .clock, .reset, .cmd, .sts, .req_data,
      .height(height_ff), .width(width_ff), .rsp_data
   );

endmodule
